>>> rtl/core/pcor_pkg.sv
// Shared types, widths and operation codes for the Pearson correlation block.
`timescale 1ns / 1ps
`default_nettype none
package pcor_pkg;

    // Default pair capacity of the sample stores.
    localparam int MAX_PAIRS_DEF = 1024;

    // Field widths.
    localparam int DATA_W  = 16;
    localparam int COUNT_W = 11;
    localparam int COEF_W  = 16;

    // Arithmetic widths, sized for the largest supported capacity of 65536 pairs.
    localparam int SUM_W  = 33;   // running sum of one series
    localparam int SQ_W   = 48;   // sum of squares or cross products
    localparam int WIDE_W = 64;   // scaled variance and covariance terms
    localparam int PROD_W = 128;  // product of two wide terms
    localparam int K_W    = 15;   // rounded coefficient magnitude, 0 to 16384

    // Wide multiply operations, in the order the controller issues them.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_N_SXX  = 3'd0;
    localparam logic [OP_W-1:0] OP_SX_SX  = 3'd1;
    localparam logic [OP_W-1:0] OP_N_SYY  = 3'd2;
    localparam logic [OP_W-1:0] OP_SY_SY  = 3'd3;
    localparam logic [OP_W-1:0] OP_N_SXY  = 3'd4;
    localparam logic [OP_W-1:0] OP_SX_SY  = 3'd5;
    localparam logic [OP_W-1:0] OP_C_C    = 3'd6;
    localparam logic [OP_W-1:0] OP_A_B    = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_value;
        logic signed [DATA_W-1:0] y_value;
        logic                     last_pair;
    } in_item_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic                     undefined;
        logic [COUNT_W-1:0]       pair_count;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            load;
        logic            walk_start;
        logic            walk_rd;
        logic            mul_start;
        logic [OP_W-1:0] mul_op;
        logic            mul_wr;
        logic [OP_W-1:0] wr_op;
        logic            root_start;
        logic            result_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic close_item;
        logic walk_last;
        logic pipe_empty;
        logic mul_done;
        logic var_bad;
        logic root_done;
        logic out_busy;
    } stat_t;

endpackage
`default_nettype wire

>>> rtl/core/pcor_mul.sv
// Sequential shift-and-add multiplier for the wide correlation terms.
`timescale 1ns / 1ps
`default_nettype none
module pcor_mul (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [pcor_pkg::WIDE_W-1:0]   a,
    input  wire logic [pcor_pkg::WIDE_W-1:0]   b,
    output logic                               done,
    output logic [pcor_pkg::PROD_W-1:0]        prod
);

    logic                          busy_reg;
    logic [pcor_pkg::PROD_W-1:0]   mcand_reg;
    logic [pcor_pkg::WIDE_W-1:0]   mplier_reg;
    logic [pcor_pkg::PROD_W-1:0]   acc_reg;

    // The product is complete once no multiplier bits remain.
    assign done = busy_reg && (mplier_reg == '0);
    assign prod = acc_reg;

    // Busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    // One multiplier bit per cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= pcor_pkg::PROD_W'(a);
            mplier_reg <= b;
            acc_reg    <= '0;
        end
        else if (busy_reg && !done)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[pcor_pkg::PROD_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[pcor_pkg::WIDE_W-1:1]};
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/pcor_root.sv
// Iterative divider and square root that round the coefficient magnitude.
`timescale 1ns / 1ps
`default_nettype none
module pcor_root (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [pcor_pkg::PROD_W-1:0]   num_sq,   // C squared
    input  wire logic [pcor_pkg::PROD_W-1:0]   den,      // A times B
    output logic                               done,
    output logic [pcor_pkg::K_W-1:0]           k
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DIV  = 2'd1;
    localparam logic [1:0] PH_SQRT = 2'd2;
    localparam int QUO_W  = 31;
    localparam int ROOT_W = 16;
    localparam int SREM_W = 18;

    logic [1:0]                    phase_reg;
    logic [4:0]                    cnt_reg;
    logic [pcor_pkg::PROD_W-1:0]   rem_reg;
    logic [QUO_W-1:0]              quo_reg;
    logic                          lsb_reg;
    logic [SREM_W-1:0]             srem_reg;
    logic [ROOT_W-1:0]             root_reg;
    logic [31:0]                   dsh_reg;
    logic [pcor_pkg::K_W-1:0]      k_reg;
    logic                          done_reg;

    logic                          bit_in;
    logic [pcor_pkg::PROD_W:0]     shifted;
    logic                          div_ge;
    logic [QUO_W-1:0]              quo_next;
    logic [SREM_W-1:0]             srem_sh;
    logic [SREM_W-1:0]             trial;
    logic                          sq_ge;
    logic [ROOT_W-1:0]             root_next;
    logic [ROOT_W:0]               root_inc;

    // Restoring division step: quotient of C*C*2^30 by A*B, one bit a cycle.
    assign bit_in   = (cnt_reg == 5'd30) ? lsb_reg : 1'b0;
    assign shifted  = {rem_reg, bit_in};
    assign div_ge   = shifted >= {1'b0, den};
    assign quo_next = {quo_reg[QUO_W-2:0], div_ge};

    // Digit-by-digit integer square root step, two radicand bits a cycle.
    assign srem_sh   = {srem_reg[SREM_W-3:0], dsh_reg[31:30]};
    assign trial     = {root_reg, 2'b01};
    assign sq_ge     = srem_sh >= trial;
    assign root_next = {root_reg[ROOT_W-2:0], sq_ge};
    assign root_inc  = (ROOT_W+1)'(root_next) + 1'b1;

    assign done = done_reg;
    assign k    = k_reg;

    // Phase control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= PH_DIV;
                        cnt_reg   <= 5'd30;
                    end
                end
                PH_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        phase_reg <= PH_SQRT;
                        cnt_reg   <= 5'd15;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                PH_SQRT:
                begin
                    if (cnt_reg == '0)
                    begin
                        phase_reg <= PH_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    // Arithmetic registers.
    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            rem_reg <= {1'b0, num_sq[pcor_pkg::PROD_W-1:1]};
            lsb_reg <= num_sq[0];
            quo_reg <= '0;
        end
        else if (phase_reg == PH_DIV)
        begin
            rem_reg <= div_ge ? pcor_pkg::PROD_W'(shifted - {1'b0, den})
                              : shifted[pcor_pkg::PROD_W-1:0];
            quo_reg <= quo_next;
            if (cnt_reg == '0)
            begin
                dsh_reg  <= {1'b0, quo_next};
                srem_reg <= '0;
                root_reg <= '0;
            end
        end
        else if (phase_reg == PH_SQRT)
        begin
            srem_reg <= sq_ge ? (srem_sh - trial) : srem_sh;
            root_reg <= root_next;
            dsh_reg  <= {dsh_reg[29:0], 2'b00};
            if (cnt_reg == '0)
            begin
                k_reg <= root_inc[pcor_pkg::K_W:1];
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/pcor_dp.sv
// Datapath: sample stores, running sums, walk pipeline, wide terms and result register.
`timescale 1ns / 1ps
`default_nettype none
module pcor_dp #(
    parameter int MAX_PAIRS = pcor_pkg::MAX_PAIRS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pcor_pkg::in_item_t   in_data,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output pcor_pkg::out_item_t       out_data,
    input  wire pcor_pkg::cmd_t       cmd,
    output pcor_pkg::stat_t           stat
);

    localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int CW = $clog2(MAX_PAIRS + 1);

    // Sample stores.
    logic signed [pcor_pkg::DATA_W-1:0] xmem [MAX_PAIRS];
    logic signed [pcor_pkg::DATA_W-1:0] ymem [MAX_PAIRS];

    logic [CW-1:0]                      count_reg;
    logic signed [pcor_pkg::SUM_W-1:0]  sx_reg;
    logic signed [pcor_pkg::SUM_W-1:0]  sy_reg;
    logic [AW-1:0]                      rd_addr_reg;
    logic                               rd_vld_reg;
    logic                               prod_vld_reg;
    logic signed [pcor_pkg::DATA_W-1:0] x_rd_reg;
    logic signed [pcor_pkg::DATA_W-1:0] y_rd_reg;
    logic signed [31:0]                 xx_reg;
    logic signed [31:0]                 yy_reg;
    logic signed [31:0]                 xy_reg;
    logic signed [pcor_pkg::SQ_W-1:0]   sxx_reg;
    logic signed [pcor_pkg::SQ_W-1:0]   syy_reg;
    logic signed [pcor_pkg::SQ_W-1:0]   sxy_reg;
    logic signed [pcor_pkg::WIDE_W-1:0] p_reg;
    logic signed [pcor_pkg::WIDE_W-1:0] a_reg;
    logic signed [pcor_pkg::WIDE_W-1:0] b_reg;
    logic signed [pcor_pkg::WIDE_W-1:0] c_reg;
    logic [pcor_pkg::PROD_W-1:0]        l_reg;
    logic [pcor_pkg::PROD_W-1:0]        pp_reg;
    logic                               out_valid_reg;
    pcor_pkg::out_item_t                out_data_reg;

    logic [CW-1:0]                      count_inc;
    logic [pcor_pkg::SUM_W-1:0]         sx_mag;
    logic [pcor_pkg::SUM_W-1:0]         sy_mag;
    logic [pcor_pkg::SQ_W-1:0]          sxy_mag;
    logic [pcor_pkg::WIDE_W-1:0]        c_mag;
    logic [pcor_pkg::WIDE_W-1:0]        n_wide;
    logic [pcor_pkg::WIDE_W-1:0]        mul_a;
    logic [pcor_pkg::WIDE_W-1:0]        mul_b;
    logic                               mul_done;
    logic [pcor_pkg::PROD_W-1:0]        mul_prod;
    logic signed [pcor_pkg::WIDE_W-1:0] prod_s;
    logic                               root_done;
    logic [pcor_pkg::K_W-1:0]           root_k;
    logic                               var_bad;
    logic [pcor_pkg::COEF_W-1:0]        k_ext;

    // Close on the marked pair or on the pair that fills the stores.
    assign count_inc = count_reg + 1'b1;

    assign stat.close_item = in_data.last_pair || (count_inc == CW'(MAX_PAIRS));
    assign stat.walk_last  = (CW'(rd_addr_reg) + 1'b1) == count_reg;
    assign stat.pipe_empty = !rd_vld_reg && !prod_vld_reg;
    assign stat.mul_done   = mul_done;
    assign stat.var_bad    = var_bad;
    assign stat.root_done  = root_done;
    assign stat.out_busy   = out_valid_reg;

    // Store writes and walk reads.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            xmem[count_reg[AW-1:0]] <= in_data.x_value;
            ymem[count_reg[AW-1:0]] <= in_data.y_value;
        end
        if (cmd.walk_rd)
        begin
            x_rd_reg <= xmem[rd_addr_reg];
            y_rd_reg <= ymem[rd_addr_reg];
        end
    end

    // Pair count, running sums and walk control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sx_reg       <= '0;
            sy_reg       <= '0;
            rd_addr_reg  <= '0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.result_load)
            begin
                count_reg <= '0;
                sx_reg    <= '0;
                sy_reg    <= '0;
            end
            else if (cmd.load)
            begin
                count_reg <= count_inc;
                sx_reg    <= sx_reg + pcor_pkg::SUM_W'(in_data.x_value);
                sy_reg    <= sy_reg + pcor_pkg::SUM_W'(in_data.y_value);
            end
            if (cmd.walk_start)
            begin
                rd_addr_reg <= '0;
            end
            else if (cmd.walk_rd)
            begin
                rd_addr_reg <= rd_addr_reg + 1'b1;
            end
            rd_vld_reg   <= cmd.walk_rd;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    // Walk pipeline: products, then accumulation.
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            xx_reg <= x_rd_reg * x_rd_reg;
            yy_reg <= y_rd_reg * y_rd_reg;
            xy_reg <= x_rd_reg * y_rd_reg;
        end
        if (cmd.walk_start)
        begin
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            sxx_reg <= sxx_reg + pcor_pkg::SQ_W'(xx_reg);
            syy_reg <= syy_reg + pcor_pkg::SQ_W'(yy_reg);
            sxy_reg <= sxy_reg + pcor_pkg::SQ_W'(xy_reg);
        end
    end

    // Operand magnitudes for the unsigned multiplier.
    assign sx_mag  = sx_reg[pcor_pkg::SUM_W-1] ? pcor_pkg::SUM_W'(-sx_reg) : sx_reg;
    assign sy_mag  = sy_reg[pcor_pkg::SUM_W-1] ? pcor_pkg::SUM_W'(-sy_reg) : sy_reg;
    assign sxy_mag = sxy_reg[pcor_pkg::SQ_W-1] ? pcor_pkg::SQ_W'(-sxy_reg) : sxy_reg;
    assign c_mag   = c_reg[pcor_pkg::WIDE_W-1] ? pcor_pkg::WIDE_W'(-c_reg) : c_reg;
    assign n_wide  = pcor_pkg::WIDE_W'(count_reg);

    // Operand selection for each wide multiply.
    always_comb
    begin
        unique case (cmd.mul_op)
            pcor_pkg::OP_N_SXX:
            begin
                mul_a = n_wide;
                mul_b = pcor_pkg::WIDE_W'(sxx_reg);
            end
            pcor_pkg::OP_SX_SX:
            begin
                mul_a = pcor_pkg::WIDE_W'(sx_mag);
                mul_b = pcor_pkg::WIDE_W'(sx_mag);
            end
            pcor_pkg::OP_N_SYY:
            begin
                mul_a = n_wide;
                mul_b = pcor_pkg::WIDE_W'(syy_reg);
            end
            pcor_pkg::OP_SY_SY:
            begin
                mul_a = pcor_pkg::WIDE_W'(sy_mag);
                mul_b = pcor_pkg::WIDE_W'(sy_mag);
            end
            pcor_pkg::OP_N_SXY:
            begin
                mul_a = n_wide;
                mul_b = pcor_pkg::WIDE_W'(sxy_mag);
            end
            pcor_pkg::OP_SX_SY:
            begin
                mul_a = pcor_pkg::WIDE_W'(sx_mag);
                mul_b = pcor_pkg::WIDE_W'(sy_mag);
            end
            pcor_pkg::OP_C_C:
            begin
                mul_a = c_mag;
                mul_b = c_mag;
            end
            pcor_pkg::OP_A_B:
            begin
                mul_a = a_reg;
                mul_b = b_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pcor_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign prod_s = $signed(mul_prod[pcor_pkg::WIDE_W-1:0]);

    // Combine products into the scaled variance and covariance terms, and hold C squared and A times B.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_wr)
        begin
            unique case (cmd.wr_op)
                pcor_pkg::OP_N_SXX: p_reg <= prod_s;
                pcor_pkg::OP_SX_SX: a_reg <= p_reg - prod_s;
                pcor_pkg::OP_N_SYY: p_reg <= prod_s;
                pcor_pkg::OP_SY_SY: b_reg <= p_reg - prod_s;
                pcor_pkg::OP_N_SXY: p_reg <= sxy_reg[pcor_pkg::SQ_W-1] ? -prod_s : prod_s;
                pcor_pkg::OP_SX_SY:
                begin
                    c_reg <= (sx_reg[pcor_pkg::SUM_W-1] ^ sy_reg[pcor_pkg::SUM_W-1])
                             ? (p_reg + prod_s) : (p_reg - prod_s);
                end
                pcor_pkg::OP_C_C:   l_reg  <= mul_prod;
                pcor_pkg::OP_A_B:   pp_reg <= mul_prod;
                default:            p_reg  <= p_reg;
            endcase
        end
    end

    assign var_bad = (a_reg <= 0) || (b_reg <= 0);

    pcor_root u_root (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.root_start),
        .num_sq (l_reg),
        .den    (pp_reg),
        .done   (root_done),
        .k      (root_k)
    );

    assign k_ext = pcor_pkg::COEF_W'(root_k);

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            out_data_reg.undefined  <= var_bad;
            out_data_reg.pair_count <= pcor_pkg::COUNT_W'(count_reg);
            if (var_bad)
            begin
                out_data_reg.coefficient <= '0;
            end
            else
            begin
                out_data_reg.coefficient <= c_reg[pcor_pkg::WIDE_W-1]
                                            ? $signed(-k_ext) : $signed(k_ext);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

>>> rtl/core/pcor_ctrl.sv
// Controller state machine that sequences loading, the walk and the wide arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module pcor_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire pcor_pkg::stat_t  stat,
    output pcor_pkg::cmd_t        cmd
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_ROOT  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [pcor_pkg::OP_W-1:0]  op_reg;
    logic [pcor_pkg::OP_W-1:0]  op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            op_reg    <= pcor_pkg::OP_N_SXX;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign in_ready = (state_reg == S_LOAD);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.wr_op  = op_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.load = in_valid;
                if (in_valid && stat.close_item)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk_rd = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = pcor_pkg::OP_N_SXX;
                    op_next       = pcor_pkg::OP_N_SXX;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                if (stat.mul_done)
                begin
                    cmd.mul_wr = 1'b1;
                    if (op_reg == pcor_pkg::OP_SX_SY)
                    begin
                        state_next = S_CHECK;
                    end
                    else if (op_reg == pcor_pkg::OP_A_B)
                    begin
                        cmd.root_start = 1'b1;
                        state_next     = S_ROOT;
                    end
                    else
                    begin
                        op_next       = op_reg + 1'b1;
                        cmd.mul_start = 1'b1;
                        cmd.mul_op    = op_reg + 1'b1;
                    end
                end
            end
            S_CHECK:
            begin
                if (stat.var_bad)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = pcor_pkg::OP_C_C;
                    op_next       = pcor_pkg::OP_C_C;
                    state_next    = S_MUL;
                end
            end
            S_ROOT:
            begin
                if (stat.root_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/pearson_correlation.sv
// Top level of the Pearson correlation block: controller plus datapath.
// Pairs are loaded while in_ready is high; after the closing pair in_ready stays low until
// the result is loaded. The block reads the n stored pairs once, then runs six sequential
// 64-bit multiplies, each ending early once no multiplier bits remain, and, unless a variance
// term is not positive, two more followed by the division and the integer square root.
// Reset clears the count, sums and control; the sample stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module pearson_correlation #(
    parameter int MAX_PAIRS = pcor_pkg::MAX_PAIRS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire pcor_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output pcor_pkg::out_item_t       out_data
);

    pcor_pkg::cmd_t  cmd;
    pcor_pkg::stat_t stat;

    pcor_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pcor_dp #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
`default_nettype wire

>>> rtl/core/pcor_checker.sv
// Port-level checks for the Pearson correlation block and their binding.
`timescale 1ns / 1ps
`default_nettype none
module pcor_assert (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire pcor_pkg::in_item_t  in_data,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire pcor_pkg::out_item_t out_data
);

    // A waiting result item holds until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    // An undefined result carries a zero coefficient.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.undefined |-> out_data.coefficient == '0)
        else $error("undefined result with nonzero coefficient");

    // The coefficient stays within plus or minus one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(out_data.coefficient) <= 16'sd16384) &&
                      ($signed(out_data.coefficient) >= -16'sd16384))
        else $error("coefficient out of range");

    // A new result needs a fresh set, so none follows directly on a taken one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result item repeated");

endmodule

bind pearson_correlation pcor_assert u_pcor_assert (.*);
`default_nettype wire
